>>> src/psmf_pkg.sv
package psmf_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  // position counter stops at the larger of the depth and 255
  localparam int unsigned CNT_CAP     = (TABLE_DEPTH > 255) ? TABLE_DEPTH : 255;
  localparam int unsigned CNT_W       = $clog2(CNT_CAP + 1);

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FOUND  = 2'd1,
    ST_SOLVED = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  // broadcast from the controller to every cell of the row
  typedef struct packed {
    logic               hold;
    logic               adv;
    logic               store;
    logic signed [32:0] need;
    logic        [31:0] wr_value;
  } cell_ctl_t;

  function automatic logic [7:0] sat8(input logic [31:0] v);
    logic [7:0] r;
    r = (v > 32'd255) ? 8'hFF : v[7:0];
    return r;
  endfunction

endpackage

>>> src/psmf_cell.sv
module psmf_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psmf_pkg::cell_ctl_t ctl_i,
  input  logic                tok_i,
  output logic                tok_o,
  output logic                hit_o
);

  logic        tok_q, tok_d;
  logic [31:0] val_q, val_d;

  always_comb begin
    // a token launched while the row is held must not be dropped
    tok_d = ctl_i.hold ? (tok_q | tok_i) : tok_i;
    val_d = (tok_q && ctl_i.store) ? ctl_i.wr_value : val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign tok_o = tok_q & ctl_i.adv;
  assign hit_o = tok_q & ({val_q[31], val_q} == ctl_i.need);

endmodule

>>> src/psmf_chain.sv
module psmf_chain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psmf_pkg::cell_ctl_t ctl_i,
  input  logic                launch_i,
  output logic                hit_any_o
);

  logic [psmf_pkg::TABLE_DEPTH-1:0] tok_in;
  logic [psmf_pkg::TABLE_DEPTH-1:0] hit_vec;

  assign tok_in[0] = launch_i;

  for (genvar i = 0; i < psmf_pkg::TABLE_DEPTH; i++) begin : g_cell
    if (i < psmf_pkg::TABLE_DEPTH - 1) begin : g_mid
      psmf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_i),
        .tok_i  (tok_in[i]),
        .tok_o  (tok_in[i+1]),
        .hit_o  (hit_vec[i])
      );
    end else begin : g_last
      // the search token never moves past the last position
      psmf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_i),
        .tok_i  (tok_in[i]),
        .tok_o  (),
        .hit_o  (hit_vec[i])
      );
    end
  end

  assign hit_any_o = |hit_vec;

endmodule

>>> src/pair_sum_match_finder_unit.sv
// Finds the first pair in a set whose sum equals target_sum. Values are kept in
// a row of cells, one per set position; a search token starts at position 0
// and steps one cell per clock, the cell that holds it comparing its value
// against target_sum minus the incoming value, so the earliest match wins. A
// storing item at position p walks the token through the p cells before it and
// then stores its value at its own cell; a pair found at an earlier position j
// ends the walk there; solved and table-full items finish without a walk.
// s_axis_tready comes back in the same cycle that the result appears in the
// output register. One item is in flight at a time; the result sits in an
// output register so the next item can be accepted while it waits, but the
// walk pauses in every cycle that a held result is not taken by m_axis_tready.
// first_of_set in tuser restarts the set. target_sum is written through
// cfg_we_i / cfg_wdata_i; the user must do so only while the block is idle,
// and the block itself does not enforce this.
module pair_sum_match_finder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
  input  logic        s_axis_tuser,   // [0] first_of_set
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] earlier_index, [15:8] current_index
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned IDX_W = psmf_pkg::IDX_W;
  localparam int unsigned CNT_W = psmf_pkg::CNT_W;

  psmf_pkg::state_e   state_q, state_d;
  psmf_pkg::status_e  kind_q, kind_d;
  logic [31:0]        target_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_eff;
  logic               solved_q, solved_d, solved_eff;
  logic [IDX_W-1:0]   pos_q, walk_q, walk_d;
  logic [7:0]         cur_q;
  logic signed [32:0] need_q, need_d;
  logic [31:0]        val_q;

  logic               m_valid_q, m_valid_d;
  psmf_pkg::status_e  m_status_q, res_status;
  logic [7:0]         m_earlier_q, res_earlier;
  logic [7:0]         m_current_q;

  psmf_pkg::cell_ctl_t ctl;
  logic               accept, launch, hold, done, at_pos, hit_any, full;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == psmf_pkg::S_IDLE);
  assign hold          = m_valid_q & ~m_axis_tready;
  assign at_pos        = (walk_q == pos_q);

  // decision at acceptance
  always_comb begin
    cnt_eff    = s_axis_tuser ? '0 : cnt_q;
    solved_eff = s_axis_tuser ? 1'b0 : solved_q;
    full       = (cnt_eff >= CNT_W'(psmf_pkg::TABLE_DEPTH));
    if (solved_eff) begin
      kind_d = psmf_pkg::ST_SOLVED;
    end else if (full) begin
      kind_d = psmf_pkg::ST_FULL;
    end else begin
      kind_d = psmf_pkg::ST_STORED;
    end
    need_d = $signed({target_q[31], target_q}) - $signed({s_axis_tdata[31], s_axis_tdata});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      psmf_pkg::S_IDLE: begin
        if (accept) state_d = psmf_pkg::S_RUN;
      end
      psmf_pkg::S_RUN: begin
        if (done) state_d = psmf_pkg::S_IDLE;
      end
      default: state_d = psmf_pkg::S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    launch       = 1'b0;
    done         = 1'b0;
    ctl.hold     = hold;
    ctl.adv      = 1'b0;
    ctl.store    = 1'b0;
    ctl.need     = need_q;
    ctl.wr_value = val_q;
    res_status   = kind_q;
    res_earlier  = 8'd0;
    case (state_q)
      psmf_pkg::S_IDLE: begin
        launch = accept && (kind_d == psmf_pkg::ST_STORED);
      end
      psmf_pkg::S_RUN: begin
        if (kind_q != psmf_pkg::ST_STORED) begin
          done = ~hold;
        end else if (!hold) begin
          // the cell at this item's own position holds no live value yet
          if (at_pos) begin
            ctl.store = 1'b1;
            done      = 1'b1;
          end else if (hit_any) begin
            done        = 1'b1;
            res_status  = psmf_pkg::ST_FOUND;
            res_earlier = psmf_pkg::sat8(32'(walk_q));
          end else begin
            ctl.adv = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    solved_d = solved_q;
    walk_d   = walk_q;
    if (accept) begin
      cnt_d    = (cnt_eff < CNT_W'(psmf_pkg::CNT_CAP)) ? CNT_W'(cnt_eff + 1'b1) : cnt_eff;
      solved_d = solved_eff;
      walk_d   = '0;
    end else begin
      if (done && (res_status == psmf_pkg::ST_FOUND)) solved_d = 1'b1;
      if (ctl.adv) walk_d = IDX_W'(walk_q + 1'b1);
    end
    m_valid_d = m_valid_q;
    if (done) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= psmf_pkg::S_IDLE;
      target_q  <= '0;
      cnt_q     <= '0;
      solved_q  <= 1'b0;
      walk_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) target_q <= cfg_wdata_i;
      cnt_q     <= cnt_d;
      solved_q  <= solved_d;
      walk_q    <= walk_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
      pos_q  <= cnt_eff[IDX_W-1:0];
      cur_q  <= psmf_pkg::sat8(32'(cnt_eff));
      need_q <= need_d;
      val_q  <= s_axis_tdata;
    end
    if (done) begin
      m_status_q  <= res_status;
      m_earlier_q <= res_earlier;
      m_current_q <= cur_q;
    end
  end

  psmf_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .launch_i  (launch),
    .hit_any_o (hit_any)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_current_q, m_earlier_q};
  assign m_axis_tuser  = m_status_q;

`ifndef ASSERT_OFF
  a_hit_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_any |-> (state_q == psmf_pkg::S_RUN))
    else $error("match seen with no search running");

  a_found_sets_solved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid) && (m_axis_tuser == psmf_pkg::ST_FOUND)) |-> solved_q)
    else $error("pair reported but set not marked solved");

  a_earlier_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != psmf_pkg::ST_FOUND)) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("earlier index nonzero without a pair");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(psmf_pkg::CNT_CAP))
    else $error("position counter beyond its cap");
`endif

endmodule
